/* src/prr_pkg.sv */
// prr_pkg: types and constants shared by the port range registry files.
// No dependencies.
`default_nettype none
package prr_pkg;
   localparam int PORT_W   = 16;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CHECK      = 2'd0,
      ACT_REGISTER   = 2'd1,
      ACT_UNREGISTER = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERLAP   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;
endpackage
`default_nettype wire

/* src/prr_req_if.sv */
// prr_req_if: request channel of the port range registry (valid/ready).
// Depends on prr_pkg for field widths.
`default_nettype none
interface prr_req_if;
   logic                            valid;
   logic                            ready;
   logic [prr_pkg::ACTION_W-1:0]    action;
   logic [prr_pkg::PORT_W-1:0]      range_start;
   logic [prr_pkg::PORT_W-1:0]      range_end;

   modport source (output valid, output action, output range_start, output range_end,
                   input ready);
   modport sink   (input valid, input action, input range_start, input range_end,
                   output ready);
endinterface
`default_nettype wire

/* src/prr_rsp_if.sv */
// prr_rsp_if: result channel of the port range registry (valid/ready).
// Depends on prr_pkg for field widths.
`default_nettype none
interface prr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [prr_pkg::STATUS_W-1:0]    status;
   logic [prr_pkg::SLOT_W-1:0]      slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface
`default_nettype wire

/* src/prr_ram.sv */
// prr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module prr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* src/port_range_registry.sv */
// port_range_registry: table of inclusive 16-bit port ranges with check,
// register and unregister. Depends on prr_pkg, prr_req_if, prr_rsp_if, prr_ram.
//
//   channel  dir  signals                                   notes
//   req_ch   in   valid ready action range_start range_end  one request at a time
//   rsp_ch   out  valid ready status slot                   one result per request
//
// A request runs in order: the accept cycle issues the first
// read, the range RAM then returns one slot per cycle, and a finish cycle
// writes back and loads the result register. Valid bits live in flops cleared
// by reset; no clearing pass. The finish waits while an earlier result is
// still held; a new request is taken while a result waits.
`default_nettype none
module port_range_registry #(
   parameter int TABLE_SLOTS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   prr_req_if.sink   req_ch,
   prr_rsp_if.source rsp_ch
);
   localparam int IDX_W  = $clog2(TABLE_SLOTS);
   localparam int PW     = prr_pkg::PORT_W;
   localparam int SW     = prr_pkg::SLOT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   prr_pkg::state_type state_ff, state_in;

   logic [TABLE_SLOTS-1:0]        valid_ff;
   logic [prr_pkg::ACTION_W-1:0]  action_ff;
   logic [PW-1:0]                 lo_ff, hi_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic                          hit_ff, free_ff;
   logic [IDX_W-1:0]              hit_idx_ff, free_idx_ff;
   logic                          rsp_valid_ff;
   logic [prr_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [SW-1:0]                 rsp_slot_ff;

   logic                          accept, out_free, finish;
   logic [PW-1:0]                 req_lo, req_hi;
   logic [2*PW-1:0]               rd_data;
   logic [PW-1:0]                 ent_first, ent_last;
   logic                          ent_valid, match;
   logic [IDX_W-1:0]              rd_addr;
   logic                          wr_en;
   logic [SW+IDX_W-1:0]           hit_ext, free_ext;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_lo   = (req_ch.range_start > req_ch.range_end) ? req_ch.range_end
                                                             : req_ch.range_start;
   assign req_hi   = (req_ch.range_start > req_ch.range_end) ? req_ch.range_start
                                                             : req_ch.range_end;

   assign ent_first = rd_data[2*PW-1:PW];
   assign ent_last  = rd_data[PW-1:0];
   assign ent_valid = valid_ff[idx_ff];
   assign match = (action_ff == prr_pkg::ACT_UNREGISTER)
                ? (ent_valid && ent_first == lo_ff && ent_last == hi_ff)
                : (ent_valid && lo_ff <= ent_last && ent_first <= hi_ff);

   assign hit_ext  = {{SW{1'b0}}, hit_idx_ff};
   assign free_ext = {{SW{1'b0}}, free_idx_ff};

   assign rd_addr = (state_ff == prr_pkg::S_IDLE) ? '0 : IDX_W'(idx_ff + 1'b1);
   assign wr_en   = finish && action_ff == prr_pkg::ACT_REGISTER && !hit_ff && free_ff;

   prr_ram #(
      .WIDTH (2 * PW),
      .DEPTH (TABLE_SLOTS)
   ) u_ranges (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx_ff),
      .wr_data ({lo_ff, hi_ff}),
      .rd_en   (1'b1),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      finish       = 1'b0;
      unique case (state_ff)
         prr_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = prr_pkg::S_SCAN;
            end
         end
         prr_pkg::S_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = prr_pkg::S_FINISH;
            end
         end
         prr_pkg::S_FINISH: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = prr_pkg::S_IDLE;
            end
         end
         default: state_in = prr_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // scan bookkeeping
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_ch.action;
         lo_ff     <= req_lo;
         hi_ff     <= req_hi;
         idx_ff    <= '0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
      end else if (state_ff == prr_pkg::S_SCAN) begin
         idx_ff <= IDX_W'(idx_ff + 1'b1);
         if (!hit_ff && match) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         if (!free_ff && !ent_valid) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (finish) begin
         if (wr_en) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end else if (action_ff == prr_pkg::ACT_UNREGISTER && hit_ff) begin
            valid_ff[hit_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         case (action_ff)
            prr_pkg::ACT_CHECK: begin
               rsp_status_ff <= hit_ff ? prr_pkg::ST_OVERLAP : prr_pkg::ST_OK;
               rsp_slot_ff   <= hit_ff ? hit_ext[SW-1:0] : '0;
            end
            prr_pkg::ACT_REGISTER: begin
               if (hit_ff) begin
                  rsp_status_ff <= prr_pkg::ST_OVERLAP;
                  rsp_slot_ff   <= hit_ext[SW-1:0];
               end else if (!free_ff) begin
                  rsp_status_ff <= prr_pkg::ST_FULL;
                  rsp_slot_ff   <= '0;
               end else begin
                  rsp_status_ff <= prr_pkg::ST_OK;
                  rsp_slot_ff   <= free_ext[SW-1:0];
               end
            end
            prr_pkg::ACT_UNREGISTER: begin
               rsp_status_ff <= hit_ff ? prr_pkg::ST_OK : prr_pkg::ST_NOT_FOUND;
               rsp_slot_ff   <= hit_ff ? hit_ext[SW-1:0] : '0;
            end
            default: begin
               rsp_status_ff <= prr_pkg::ST_OK;
               rsp_slot_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.slot   = rsp_slot_ff;
endmodule
`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for port_range_registry. A directed request table, then random
// check/register/unregister traffic, scored against fixed replies (typed rows) or a bench range table.
// Depends on prr_pkg, prr_req_if, prr_rsp_if and the port_range_registry RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS  = 16;
   localparam int RANDOM_COUNT = 1600;
   localparam int QUIET_LIMIT  = 4000;
   localparam int STALL_CYCLES = 300;
   localparam int MAX_PORT     = 65535;

   typedef struct {
      prr_pkg::status_type        status;
      logic [prr_pkg::SLOT_W-1:0] slot;
   } reply_type;

   typedef struct {
      prr_pkg::action_type        act;
      logic [prr_pkg::PORT_W-1:0] first;
      logic [prr_pkg::PORT_W-1:0] last;
      bit                         typed;
      prr_pkg::status_type        status;
      logic [prr_pkg::SLOT_W-1:0] slot;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   prr_req_if req_ch();
   prr_rsp_if rsp_ch();

   port_range_registry #(.TABLE_SLOTS(TABLE_SLOTS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // bench copy of the range table
   bit                         slot_used  [TABLE_SLOTS];
   logic [prr_pkg::PORT_W-1:0] slot_first [TABLE_SLOTS];
   logic [prr_pkg::PORT_W-1:0] slot_last  [TABLE_SLOTS];

   reply_type pending_replies[$];
   int        accepted_requests = 0;
   int        quiet_cycles      = 0;
   int        failures          = 0;
   bit        calm              = 1'b0;

   function automatic reply_type apply_request(prr_pkg::action_type act,
                                               logic [prr_pkg::PORT_W-1:0] a,
                                               logic [prr_pkg::PORT_W-1:0] b);
      logic [prr_pkg::PORT_W-1:0] lo;
      logic [prr_pkg::PORT_W-1:0] hi;
      int                         hit;
      int                         free;
      int                         match;
      reply_type                  r;
      lo    = (a > b) ? b : a;
      hi    = (a > b) ? a : b;
      hit   = -1;
      free  = -1;
      match = -1;
      r.status = prr_pkg::ST_OK;
      r.slot   = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (hit < 0 && slot_used[i] && lo <= slot_last[i] && slot_first[i] <= hi)
            hit = i;
         if (free < 0 && !slot_used[i])
            free = i;
         if (match < 0 && slot_used[i] && slot_first[i] == lo && slot_last[i] == hi)
            match = i;
      end
      case (act)
         prr_pkg::ACT_CHECK: begin
            if (hit >= 0) begin
               r.status = prr_pkg::ST_OVERLAP;
               r.slot   = hit[prr_pkg::SLOT_W-1:0];
            end
         end
         prr_pkg::ACT_REGISTER: begin
            if (hit >= 0) begin
               r.status = prr_pkg::ST_OVERLAP;
               r.slot   = hit[prr_pkg::SLOT_W-1:0];
            end else if (free < 0) begin
               r.status = prr_pkg::ST_FULL;
            end else begin
               slot_used[free]  = 1'b1;
               slot_first[free] = lo;
               slot_last[free]  = hi;
               r.slot           = free[prr_pkg::SLOT_W-1:0];
            end
         end
         prr_pkg::ACT_UNREGISTER: begin
            if (match < 0) begin
               r.status = prr_pkg::ST_NOT_FOUND;
            end else begin
               slot_used[match] = 1'b0;
               r.slot           = match[prr_pkg::SLOT_W-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // offer one request, wait for the handshake, then record the expected reply
   task automatic issue(prr_pkg::action_type act, logic [prr_pkg::PORT_W-1:0] a,
                        logic [prr_pkg::PORT_W-1:0] b, bit typed, reply_type fixed);
      reply_type r;
      if (!calm && $urandom_range(99) < 6) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.range_start <= a;
      req_ch.range_end   <= b;
      do @(posedge clock); while (!req_ch.ready);
      accepted_requests++;
      r = apply_request(act, a, b);
      pending_replies.push_back(typed ? fixed : r);
   endtask

   task automatic random_request(int reg_pct, int unreg_pct);
      int                  used[$];
      int                  pick;
      int                  roll;
      int                  w;
      int                  lo;
      int                  hi;
      prr_pkg::action_type act;
      reply_type           unused;
      unused.status = prr_pkg::ST_OK;
      unused.slot   = '0;
      pick          = 0;
      for (int i = 0; i < TABLE_SLOTS; i++)
         if (slot_used[i]) used.push_back(i);
      if (used.size() > 0) pick = used[$urandom_range(used.size() - 1)];
      roll = $urandom_range(99);
      act  = (roll < reg_pct) ? prr_pkg::ACT_REGISTER :
             (roll < reg_pct + unreg_pct) ? prr_pkg::ACT_UNREGISTER : prr_pkg::ACT_CHECK;
      w    = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(63);
      lo   = $urandom_range(MAX_PORT);
      hi   = lo + w;
      if (act == prr_pkg::ACT_UNREGISTER && used.size() > 0 && $urandom_range(99) < 80) begin
         lo = int'(slot_first[pick]);
         hi = int'(slot_last[pick]);
         // near miss on one end
         if ($urandom_range(4) == 0) begin
            if ($urandom_range(1)) lo = lo + 1;
            else hi = hi - 1;
         end
      end else if (used.size() > 0 && $urandom_range(99) < 40) begin
         case ($urandom_range(4))
            0: begin lo = int'(slot_last[pick]);      hi = lo + w; end
            1: begin lo = int'(slot_last[pick]) + 1;  hi = lo + w; end
            2: begin hi = int'(slot_first[pick]);     lo = hi - w; end
            3: begin hi = int'(slot_first[pick]) - 1; lo = hi - w; end
            default: begin
               lo = int'(slot_first[pick]) - w;
               hi = int'(slot_last[pick]) + w;
            end
         endcase
      end else if ($urandom_range(29) == 0) begin
         lo = $urandom_range(MAX_PORT);
         hi = $urandom_range(MAX_PORT);
      end
      lo = (lo < 0) ? 0 : (lo > MAX_PORT) ? MAX_PORT : lo;
      hi = (hi < 0) ? 0 : (hi > MAX_PORT) ? MAX_PORT : hi;
      if ($urandom_range(4) == 0)
         issue(act, hi[prr_pkg::PORT_W-1:0], lo[prr_pkg::PORT_W-1:0], 1'b0, unused);
      else
         issue(act, lo[prr_pkg::PORT_W-1:0], hi[prr_pkg::PORT_W-1:0], 1'b0, unused);
   endtask

   // result side: scoring, random back-pressure and one long hold-off
   initial begin
      int        stall_left;
      bit        stalled;
      reply_type want;
      stall_left = 0;
      stalled    = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
               $error("unexpected result: status %0d slot %0d", rsp_ch.status, rsp_ch.slot);
               failures++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  failures++;
               end
               if (rsp_ch.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_ch.slot);
                  failures++;
               end
            end
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!stalled && accepted_requests >= 300) begin
            stalled    = 1'b1;
            stall_left = STALL_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 6);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("** port_range_registry: FAILED **");
      $finish;
   end

   initial begin
      script_row_type script[26];
      reply_type      fixed;
      int             reg_pct;
      int             unreg_pct;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= prr_pkg::ACT_CHECK;
      req_ch.range_start <= '0;
      req_ch.range_end   <= '0;
      reg_pct            = 40;
      unreg_pct          = 20;
      script = '{
         '{prr_pkg::ACT_CHECK,      16'h0000, 16'hFFFF, 1'b1, prr_pkg::ST_OK,        4'd0},
         '{prr_pkg::ACT_REGISTER,   16'h0000, 16'h0000, 1'b1, prr_pkg::ST_OK,        4'd0},
         '{prr_pkg::ACT_REGISTER,   16'hFFFF, 16'hFFFF, 1'b1, prr_pkg::ST_OK,        4'd1},
         '{prr_pkg::ACT_CHECK,      16'h0000, 16'hFFFF, 1'b1, prr_pkg::ST_OVERLAP,   4'd0},
         '{prr_pkg::ACT_REGISTER,   16'h0064, 16'h0032, 1'b1, prr_pkg::ST_OK,        4'd2},
         '{prr_pkg::ACT_CHECK,      16'h0064, 16'h0064, 1'b0, prr_pkg::ST_OK,        4'd0},
         '{prr_pkg::ACT_REGISTER,   16'h0028, 16'h003C, 1'b0, prr_pkg::ST_OK,        4'd0},
         '{prr_pkg::ACT_UNREGISTER, 16'h0064, 16'h0032, 1'b1, prr_pkg::ST_OK,        4'd2},
         '{prr_pkg::ACT_UNREGISTER, 16'h0032, 16'h0064, 1'b1, prr_pkg::ST_NOT_FOUND, 4'd0},
         '{prr_pkg::ACT_REGISTER,   16'h2000, 16'h20FF, 1'b1, prr_pkg::ST_OK,        4'd2},
         '{prr_pkg::ACT_REGISTER,   16'h3000, 16'h30FF, 1'b1, prr_pkg::ST_OK,        4'd3},
         '{prr_pkg::ACT_REGISTER,   16'h4000, 16'h40FF, 1'b1, prr_pkg::ST_OK,        4'd4},
         '{prr_pkg::ACT_REGISTER,   16'h5000, 16'h50FF, 1'b1, prr_pkg::ST_OK,        4'd5},
         '{prr_pkg::ACT_REGISTER,   16'h6000, 16'h60FF, 1'b1, prr_pkg::ST_OK,        4'd6},
         '{prr_pkg::ACT_REGISTER,   16'h7000, 16'h70FF, 1'b1, prr_pkg::ST_OK,        4'd7},
         '{prr_pkg::ACT_REGISTER,   16'h8000, 16'h80FF, 1'b1, prr_pkg::ST_OK,        4'd8},
         '{prr_pkg::ACT_REGISTER,   16'h9000, 16'h90FF, 1'b1, prr_pkg::ST_OK,        4'd9},
         '{prr_pkg::ACT_REGISTER,   16'hA000, 16'hA0FF, 1'b1, prr_pkg::ST_OK,        4'd10},
         '{prr_pkg::ACT_REGISTER,   16'hB000, 16'hB0FF, 1'b1, prr_pkg::ST_OK,        4'd11},
         '{prr_pkg::ACT_REGISTER,   16'hC000, 16'hC0FF, 1'b1, prr_pkg::ST_OK,        4'd12},
         '{prr_pkg::ACT_REGISTER,   16'hD000, 16'hD0FF, 1'b1, prr_pkg::ST_OK,        4'd13},
         '{prr_pkg::ACT_REGISTER,   16'hE000, 16'hE0FF, 1'b1, prr_pkg::ST_OK,        4'd14},
         '{prr_pkg::ACT_REGISTER,   16'hF000, 16'hF0FF, 1'b1, prr_pkg::ST_OK,        4'd15},
         '{prr_pkg::ACT_REGISTER,   16'h8800, 16'h8800, 1'b1, prr_pkg::ST_FULL,      4'd0},
         '{prr_pkg::ACT_UNREGISTER, 16'h7000, 16'h70FF, 1'b1, prr_pkg::ST_OK,        4'd7},
         '{prr_pkg::ACT_REGISTER,   16'h7100, 16'h7100, 1'b0, prr_pkg::ST_OK,        4'd0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         fixed.status = script[i].status;
         fixed.slot   = script[i].slot;
         issue(script[i].act, script[i].first, script[i].last, script[i].typed, fixed);
      end

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         // action mix drifts so the table swings between empty and full
         if (n % 100 == 0) begin
            reg_pct   = $urandom_range(15, 55);
            unreg_pct = $urandom_range(10, 40);
         end
         calm = (n >= 700 && n < 1000);
         if (n % 400 == 399) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (pending_replies.size() != 0);
         end
         random_request(reg_pct, unreg_pct);
      end
      req_ch.valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (2 * TABLE_SLOTS) @(posedge clock);
      if (failures == 0)
         $display("** port_range_registry: PASSED **");
      else
         $display("** port_range_registry: FAILED **");
      $finish;
   end
endmodule
